// File: src/cpd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cpd_pkg;

   // Longest frame tracked; the byte position saturates one below this.
   localparam int MAX_FRAME_BYTES = 512;
   localparam int POS_W = $clog2(MAX_FRAME_BYTES);

   localparam logic [7:0]  HDR_FIRST  = 8'h69;
   localparam logic [7:0]  HDR_SECOND = 8'h68;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;

   // Frame positions with a meaning of their own.
   localparam logic [POS_W-1:0] POS_HDR_FIRST  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR_SECOND = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LENGTH     = POS_W'(2);
   localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(3);
   localparam logic [POS_W-1:0] POS_MIN_LAST   = POS_W'(5);
   localparam logic [POS_W-1:0] POS_FIRST_PAY  = POS_W'(6);
   localparam logic [POS_W-1:0] POS_MAX        = POS_W'(MAX_FRAME_BYTES - 1);

   // One input byte can cause at most a payload beat and a status beat.
   localparam int MAX_RESULTS = 2;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Result queue between the checker and the output port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_TDATA_W = 32;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HEADER = 2'd1,
      ERR_CRC    = 2'd2,
      ERR_SHORT  = 2'd3
   } error_type;

   typedef struct packed {
      kind_type   out_kind;
      logic [7:0] payload_byte;
      logic       frame_ok;
      error_type  error_code;
      logic [7:0] message_type;
      logic [7:0] data_length;
      logic       out_end;
   } result_type;

   // Results produced by one accepted byte, in delivery order.
   typedef struct packed {
      logic [RES_CNT_W-1:0] count;
      result_type           first;
      result_type           second;
   } push_type;

   // CRC-16, polynomial 0x1021, MSB first, one byte per call.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  x;
      logic [15:0] xw;
      x  = crc[15:8] ^ b;
      x  = x ^ (x >> 4);
      xw = {8'h00, x};
      return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
   endfunction

endpackage

// File: src/cpd_frame_check.sv
// Frame state and per-byte checking: header, CRC, delay line and results.
// Depends on cpd_pkg for types, constants and crc_feed.
`timescale 1ns / 1ps

module cpd_frame_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic [7:0]        rx_byte,
   input  logic              rx_last,
   output cpd_pkg::push_type push
);
   import cpd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       d0_ff, d0_in, d1_ff, d1_in;
   logic             hdr_ff, hdr_in;
   logic [7:0]       len_ff, len_in, typ_ff, typ_in;

   logic       hdr_now;
   logic [7:0] len_now, typ_now;
   logic [15:0] crc_now;
   logic        pay_hit;
   result_type  pay_res, stat_res;
   error_type   err;

   always_comb begin
      hdr_now = hdr_ff;
      if (pos_ff == POS_HDR_FIRST && rx_byte != HDR_FIRST) begin
         hdr_now = 1'b0;
      end
      if (pos_ff == POS_HDR_SECOND && rx_byte != HDR_SECOND) begin
         hdr_now = 1'b0;
      end
      len_now = (pos_ff == POS_LENGTH) ? rx_byte : len_ff;
      typ_now = (pos_ff == POS_TYPE) ? rx_byte : typ_ff;
      // The byte leaving the delay line is two positions back.
      crc_now = (pos_ff >= POS_LENGTH) ? crc_feed(crc_ff, d1_ff) : crc_ff;
      pay_hit = (pos_ff >= POS_FIRST_PAY);

      priority if (pos_ff < POS_MIN_LAST) begin
         err = ERR_SHORT;
      end else if (!hdr_now) begin
         err = ERR_HEADER;
      end else if ({d0_ff, rx_byte} != crc_now) begin
         err = ERR_CRC;
      end else begin
         err = ERR_NONE;
      end

      pay_res = '{out_kind: KIND_PAYLOAD, payload_byte: d1_ff, frame_ok: 1'b0,
                  error_code: ERR_NONE, message_type: 8'h00, data_length: 8'h00,
                  out_end: !rx_last};
      stat_res = '{out_kind: KIND_STATUS, payload_byte: 8'h00,
                   frame_ok: (err == ERR_NONE), error_code: err,
                   message_type: typ_now, data_length: len_now, out_end: 1'b1};

      push.count  = RES_CNT_W'(0);
      push.first  = pay_res;
      push.second = stat_res;
      if (in_fire) begin
         push.count = RES_CNT_W'({1'b0, pay_hit}) + RES_CNT_W'({1'b0, rx_last});
      end
      if (!pay_hit) begin
         push.first = stat_res;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      d0_in  = d0_ff;
      d1_in  = d1_ff;
      hdr_in = hdr_ff;
      len_in = len_ff;
      typ_in = typ_ff;
      if (in_fire) begin
         if (rx_last) begin
            pos_in = '0;
            crc_in = CRC_INIT;
            d0_in  = 8'h00;
            d1_in  = 8'h00;
            hdr_in = 1'b1;
            len_in = 8'h00;
            typ_in = 8'h00;
         end else begin
            pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
            crc_in = crc_now;
            d0_in  = rx_byte;
            d1_in  = d0_ff;
            hdr_in = hdr_now;
            len_in = len_now;
            typ_in = typ_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
         d0_ff  <= 8'h00;
         d1_ff  <= 8'h00;
         hdr_ff <= 1'b1;
         len_ff <= 8'h00;
         typ_ff <= 8'h00;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         d0_ff  <= d0_in;
         d1_ff  <= d1_in;
         hdr_ff <= hdr_in;
         len_ff <= len_in;
         typ_ff <= typ_in;
      end
   end

endmodule

// File: src/cpd_result_queue.sv
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on cpd_pkg for result_type, push_type and the queue sizes.
`timescale 1ns / 1ps

module cpd_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  cpd_pkg::push_type   push,
   output logic                room,
   output logic                head_valid,
   input  logic                head_taken,
   output cpd_pkg::result_type head
);
   import cpd_pkg::*;

   result_type         q_ff [QUEUE_DEPTH];
   logic [QADDR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               pop;
   logic [QADDR_W-1:0] wnext;

   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rptr_ff];
   assign room       = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign pop        = head_valid && head_taken;
   assign wnext      = wptr_ff + QADDR_W'(1);

   always_comb begin
      wptr_in = wptr_ff + QADDR_W'(push.count);
      rptr_in = pop ? rptr_ff + QADDR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         q_ff[wptr_ff] <= push.first;
      end
      if (push.count == RES_CNT_W'(MAX_RESULTS)) begin
         q_ff[wnext] <= push.second;
      end
   end

endmodule

// File: src/crc16_packet_deframer_top.sv
// Top level of the CRC-16 packet deframer: byte stream in, result beats out.
// Depends on cpd_pkg, cpd_frame_check and cpd_result_queue.
`timescale 1ns / 1ps

// The deframer takes one received byte per beat, with tlast on the final byte
// of a frame. A frame is 0x69, 0x68, a length byte, a type byte, the payload
// and a big-endian CRC-16 (polynomial 0x1021, initial value 0xFFFF) computed
// over every byte except the two checksum bytes. Payload bytes leave as
// result beats with tuser low, two input bytes after they arrive; the final
// byte of the frame adds a status beat with tuser high that reports whether
// the frame is good, an error code (bad header, checksum mismatch, or a frame
// shorter than six bytes), the type byte and the length byte. The length byte
// is reported but not checked against the frame size. An input byte is
// accepted every cycle as long as at most two result beats wait in the
// four-entry result queue; with the output side always ready the block runs
// at one byte per cycle, and only the status beat at the end of a frame adds
// one extra output beat. The per-byte CRC update and all checks are
// combinational in the frame checker; its results are registered in the queue.

module crc16_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // rx_last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [8] frame_ok, [10:9] error_code,
   // [18:11] message_type, [26:19] data_length, [31:27] zero
   output logic [cpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic        rsp_tuser,   // out_kind
   output logic        rsp_tlast    // out_end
);
   import cpd_pkg::*;

   logic       in_fire;
   push_type   push;
   result_type head;

   // A byte is taken only when the queue can absorb both results it may cause.
   assign in_fire = req_tvalid && req_tready;

   cpd_frame_check u_check (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .rx_byte (req_tdata),
      .rx_last (req_tlast),
      .push    (push)
   );

   cpd_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (req_tready),
      .head_valid (rsp_tvalid),
      .head_taken (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = {5'b00000, head.data_length, head.message_type,
                       head.error_code, head.frame_ok, head.payload_byte};
   assign rsp_tuser = head.out_kind;
   assign rsp_tlast = head.out_end;

endmodule

// File: test/crc16_packet_deframer_checker.sv
// Checker for the CRC-16 packet deframer: tracks frames on the byte channel,
// predicts the result beats and compares them with the result channel.
// Depends on cpd_pkg for the result layout, codes and frame positions.
`timescale 1ns / 1ps

module crc16_packet_deframer_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [cpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tlast,
   output int                              fail_count,
   output int                              pending
);
   import cpd_pkg::*;

   result_type       owed_beats[$];
   int               mismatches = 0;

   // Frame tracking state.
   logic [POS_W-1:0] frame_pos;
   logic [15:0]      crc_acc;
   logic [7:0]       held_byte [2];
   logic             hdr_ok;
   logic [7:0]       len_byte;
   logic [7:0]       type_byte;

   // Bit-serial CRC-16, polynomial 0x1021, MSB first.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

   task automatic clear_frame();
      frame_pos    = '0;
      crc_acc      = CRC_INIT;
      held_byte[0] = 8'h00;
      held_byte[1] = 8'h00;
      hdr_ok       = 1'b1;
      len_byte     = 8'h00;
      type_byte    = 8'h00;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // Works out the beats caused by one accepted byte and queues them.
   task automatic deframe_byte(input logic [7:0] b, input logic last);
      result_type  r;
      error_type   err;
      logic [15:0] rx_crc;
      if (frame_pos == POS_HDR_FIRST && b != HDR_FIRST) hdr_ok = 1'b0;
      if (frame_pos == POS_HDR_SECOND && b != HDR_SECOND) hdr_ok = 1'b0;
      if (frame_pos == POS_LENGTH) len_byte = b;
      if (frame_pos == POS_TYPE) type_byte = b;
      // The byte leaving the two-byte delay line is hashed, so the
      // checksum bytes themselves never enter the CRC.
      if (frame_pos >= POS_LENGTH) crc_acc = crc_step(crc_acc, held_byte[1]);
      if (frame_pos >= POS_FIRST_PAY) begin
         r              = '0;
         r.out_kind     = KIND_PAYLOAD;
         r.payload_byte = held_byte[1];
         r.out_end      = !last;
         owed_beats.push_back(r);
      end
      if (last) begin
         rx_crc = {held_byte[0], b};
         if (frame_pos < POS_MIN_LAST) err = ERR_SHORT;
         else if (!hdr_ok) err = ERR_HEADER;
         else if (rx_crc != crc_acc) err = ERR_CRC;
         else err = ERR_NONE;
         r              = '0;
         r.out_kind     = KIND_STATUS;
         r.frame_ok     = (err == ERR_NONE);
         r.error_code   = err;
         r.message_type = type_byte;
         r.data_length  = len_byte;
         r.out_end      = 1'b1;
         owed_beats.push_back(r);
         clear_frame();
      end else begin
         held_byte[1] = held_byte[0];
         held_byte[0] = b;
         if (frame_pos != POS_MAX) frame_pos = frame_pos + POS_W'(1);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         owed_beats.delete();
         clear_frame();
      end else begin
         // A result beat can never stem from a byte accepted at the same
         // edge, so the output side is checked before the new byte is tracked.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_beats.size() == 0) begin
               report("unexpected result beat", rsp_tdata, 0);
            end else begin
               want = owed_beats.pop_front();
               if (rsp_tuser !== want.out_kind)
                  report("kind", 32'(rsp_tuser), 32'(want.out_kind));
               if (rsp_tdata[7:0] !== want.payload_byte)
                  report("payload byte", 32'(rsp_tdata[7:0]), 32'(want.payload_byte));
               if (rsp_tdata[8] !== want.frame_ok)
                  report("frame ok", 32'(rsp_tdata[8]), 32'(want.frame_ok));
               if (rsp_tdata[10:9] !== want.error_code)
                  report("error code", 32'(rsp_tdata[10:9]), 32'(want.error_code));
               if (rsp_tdata[18:11] !== want.message_type)
                  report("message type", 32'(rsp_tdata[18:11]), 32'(want.message_type));
               if (rsp_tdata[26:19] !== want.data_length)
                  report("data length", 32'(rsp_tdata[26:19]), 32'(want.data_length));
               if (rsp_tdata[RSP_TDATA_W-1:27] !== '0)
                  report("padding", 32'(rsp_tdata[RSP_TDATA_W-1:27]), 0);
               if (rsp_tlast !== want.out_end)
                  report("end flag", 32'(rsp_tlast), 32'(want.out_end));
            end
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata, req_tlast);
      end
      pending    <= owed_beats.size();
      fail_count <= mismatches;
   end

endmodule

// File: test/crc16_packet_deframer_top_test.sv
// Top of the packet deframer test: clock, reset, frame stimulus, output stalls
// and the verdict. Depends on cpd_pkg, the deframer RTL and the checker module.
`timescale 1ns / 1ps

module crc16_packet_deframer_top_test;
   import cpd_pkg::*;

   // The random part stops once about this many bytes have been sent.
   localparam int RUN_BYTES      = 1050;
   // Cycles without any beat on either channel before the run is abandoned.
   // The longest correct quiet stretch is the forced output hold-off below.
   localparam int IDLE_LIMIT     = 2000;
   localparam int HOLD_CYCLES    = 300;
   // One frame long enough to drive the byte position into saturation.
   localparam int OVERLONG_BYTES = 515;
   // Settling time after the last expected beat, far above the block's latency.
   localparam int SETTLE_CYCLES  = 20;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] rx_byte
   logic                   req_tlast;   // rx_last
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [7:0] payload_byte, [8] frame_ok, [10:9] error_code,
   // [18:11] message_type, [26:19] data_length, [31:27] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;   // out_kind
   logic                   rsp_tlast;   // out_end

   int                     fail_count;
   int                     pending;
   int                     idle_cycles = 0;
   int                     bytes_sent = 0;

   // The frame being sent; random frames are built here before they go out.
   logic [7:0]             frame_buf [0:OVERLONG_BYTES-1];
   int                     frame_len;

   // tx_calm and rx_calm switch off the random gaps on their side, so that
   // stretches of back-to-back beats occur too.
   bit                     tx_calm = 1'b0;
   bit                     rx_calm = 1'b0;
   // The sender arms the long output hold-off; the receiver takes it once.
   bit                     hold_armed = 1'b0;
   bit                     hold_taken = 1'b0;

   crc16_packet_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   crc16_packet_deframer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths come from three ranges: mostly the shortest, sometimes the
   // middle one, and now and then a long pause from the widest.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Offers one byte and holds it until the block takes it. After the beat
   // the sender may go idle; while idle the data lines carry junk, which the
   // block has to ignore. When no gap follows, the next call keeps tvalid high
   // without lowering it first.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int idle;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (!tx_calm && $urandom_range(0, 99) < 30) begin
         idle = gap_len();
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_len; i++) begin
         send_byte(frame_buf[i], i == frame_len - 1);
      end
   endtask

   // Writes the big-endian checksum over all bytes but the last two. The
   // package's byte update is used here only to build well-formed frames;
   // the checker computes its own CRC, so a wrong update still shows up.
   task automatic seal_crc();
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < frame_len - 2; i++) begin
         c = crc_feed(c, frame_buf[i]);
      end
      frame_buf[frame_len-2] = c[15:8];
      frame_buf[frame_len-1] = c[7:0];
   endtask

   // A correct frame of n bytes. The length byte normally matches the payload
   // size, but sometimes it is random since the block does not check it.
   task automatic make_good_frame(input int n);
      frame_len    = n;
      frame_buf[0] = HDR_FIRST;
      frame_buf[1] = HDR_SECOND;
      frame_buf[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(n - 6);
      for (int i = 3; i < n; i++) begin
         frame_buf[i] = 8'($urandom);
      end
      seal_crc();
   endtask

   // Directed frames: up to five leading bytes from lead (first byte in the
   // top bits), optionally sealed and then with chosen checksum bits flipped.
   task automatic send_directed(input int n, input logic [39:0] lead, input bit seal,
                                input logic [15:0] crc_flip);
      frame_len = n;
      for (int i = 0; i < n; i++) begin
         frame_buf[i] = (i < 5) ? lead[39 - 8*i -: 8] : 8'h00;
      end
      if (seal) begin
         seal_crc();
         frame_buf[n-2] ^= crc_flip[15:8];
         frame_buf[n-1] ^= crc_flip[7:0];
      end
      send_frame();
   endtask

   // Most random frames are well formed, so that payload and good status
   // beats dominate; the rest carry a broken header, a broken checksum, too
   // few bytes, or are plain noise.
   task automatic send_random_frame();
      int pick;
      int n;
      pick    = $urandom_range(0, 99);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (pick < 65) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 48) : $urandom_range(6, 20);
         make_good_frame(n);
      end else if (pick < 73) begin
         // Resealed after the flip, so only the header is wrong.
         make_good_frame($urandom_range(6, 16));
         frame_buf[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
         seal_crc();
      end else if (pick < 81) begin
         make_good_frame($urandom_range(6, 16));
         frame_buf[frame_len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (pick < 89) begin
         // Too short: between one and five bytes, half of them with a header.
         frame_len = $urandom_range(1, 5);
         for (int i = 0; i < frame_len; i++) begin
            frame_buf[i] = 8'($urandom);
         end
         if ($urandom_range(0, 1) == 1) begin
            frame_buf[0] = HDR_FIRST;
            if (frame_len > 1) frame_buf[1] = HDR_SECOND;
         end
      end else begin
         frame_len = $urandom_range(1, 24);
         for (int i = 0; i < frame_len; i++) begin
            frame_buf[i] = 8'($urandom);
         end
      end
      send_frame();
   endtask

   // Stops offering bytes until every expected beat has come out. The checker
   // updates its count through a register, hence the first wait.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side: mostly ready, with random stalls, calm stretches and the
   // one long hold-off, during which the sender keeps offering bytes so that
   // the result queue fills and the input stalls.
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
         if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      end
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit overlong_done;
      bit paused;
      overlong_done = 1'b0;
      paused        = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Good frame with a one-byte payload: length 0x00, type 0xFF and a
      // payload byte of 0xFF.
      send_directed(7, 40'h69_68_00_FF_FF, 1'b1, 16'h0000);
      // Wrong first header byte with a correct checksum: bad header.
      send_directed(6, 40'h00_68_FF_00_00, 1'b1, 16'h0000);
      // A lone byte with the frame flag: too short, type and length read zero.
      send_directed(1, 40'h69_00_00_00_00, 1'b0, 16'h0000);
      // Four bytes with swapped header bytes: too short wins over bad header.
      send_directed(4, 40'h68_69_12_34_00, 1'b0, 16'h0000);
      // Smallest full frame with one checksum bit flipped: checksum mismatch.
      send_directed(6, 40'h69_68_00_01_00, 1'b1, 16'h0001);
      drain();

      while (bytes_sent < RUN_BYTES) begin
         if (!overlong_done && bytes_sent >= 300) begin
            // Runs the byte position into saturation; the frame is still
            // well formed, since the checksum covers every byte anyway.
            tx_calm = 1'b0;
            make_good_frame(OVERLONG_BYTES);
            send_frame();
            overlong_done = 1'b1;
         end else begin
            send_random_frame();
         end
         if (bytes_sent >= 150) hold_armed = 1'b1;
         if (!paused && bytes_sent >= 700) begin
            drain();
            paused = 1'b1;
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
